@@ rtl/dteu_pkg.sv @@
package dteu_pkg;

  localparam int TABLE_LEN          = 24;
  localparam int DEF_CORDIC_STAGES  = 16;
  localparam int DEF_COORD_WIDTH    = 16;
  localparam int FIELD_W            = 16;
  localparam int ANG1_W             = 32;
  localparam int ANG2_W             = 34;

  // 1/K of the cordic gain in q0.16
  localparam logic [16:0] INV_GAIN_Q16 = 17'd39797;

  localparam logic [ANG1_W-1:0] TURN_HALF    = 32'h8000_0000;
  localparam logic [ANG2_W-1:0] TURN_QUARTER = 34'h0_4000_0000;

  localparam logic [FIELD_W-1:0] U_QUARTER       = 16'd16384;
  localparam logic [FIELD_W-1:0] U_HALF          = 16'd32768;
  localparam logic [FIELD_W-1:0] U_THREE_QUARTER = 16'd49152;
  localparam logic [FIELD_W-1:0] U_ZERO          = 16'd0;
  localparam logic [FIELD_W-1:0] V_ZERO          = 16'd0;
  localparam logic [FIELD_W-1:0] V_HALF          = 16'd32768;
  localparam logic [FIELD_W-1:0] V_MAX           = 16'd65535;

  // arctangent of 2^-i in units of 2^-32 turn
  localparam logic [ANG1_W-1:0] ATAN_TURNS [TABLE_LEN] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10680350,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81
  };

endpackage

@@ rtl/direction_to_equirect_uv_top.sv @@
// throughput: one transaction per cycle while the output is not stalled, set by the fully unrolled cordic pipeline
// a stalled output holds the whole pipeline in place; nothing is lost or repeated
// rst (synchronous, active high) clears all valid bits; the data registers are not reset
module direction_to_equirect_uv_top #(
  parameter int CORDIC_STAGES = dteu_pkg::DEF_CORDIC_STAGES,
  parameter int COORD_WIDTH   = dteu_pkg::DEF_COORD_WIDTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // dir_x [15:0], dir_y [31:16], dir_z [47:32]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata    // tex_u [15:0], tex_v [31:16]
);
  import dteu_pkg::*;

  localparam int NS  = (CORDIC_STAGES > TABLE_LEN) ? TABLE_LEN : CORDIC_STAGES;
  localparam int AW  = COORD_WIDTH + 4;
  localparam int WW  = AW + FIELD_W;
  localparam int PW  = AW + 17;
  localparam int SHL = (COORD_WIDTH >= 15) ? COORD_WIDTH - 15 : 0;
  localparam int SHR = (COORD_WIDTH < 15) ? 15 - COORD_WIDTH : 0;

  typedef struct packed {
    logic signed [AW-1:0] vy;
    logic                 y_pos;
    logic                 y_neg;
    logic                 u_spec;
    logic [FIELD_W-1:0]   u_fix;
  } p1_side_t;

  typedef struct packed {
    logic [FIELD_W-1:0] u;
    logic               v_spec;
    logic [FIELD_W-1:0] v_fix;
  } p2_side_t;

  function automatic logic signed [AW-1:0] scale_in(input logic signed [FIELD_W-1:0] v);
    logic signed [WW-1:0] w;
    w = WW'(v);
    w = (w <<< SHL) >>> SHR;
    return w[AW-1:0];
  endfunction

  logic en;
  assign en = !m_tvalid || m_tready;
  assign s_tready = en;

  logic signed [FIELD_W-1:0] in_x, in_y, in_z;
  assign in_x = s_tdata[15:0];
  assign in_y = s_tdata[31:16];
  assign in_z = s_tdata[47:32];

  // pass one: azimuth
  logic                     p1_vld  [NS+1];
  logic signed [AW-1:0]     p1_a    [NS+1];
  logic signed [AW-1:0]     p1_b    [NS+1];
  logic [ANG1_W-1:0]        p1_ang  [NS+1];
  p1_side_t                 p1_side [NS+1];

  logic signed [AW-1:0] sx, sz;
  assign sx = scale_in(in_x);
  assign sz = scale_in(in_z);

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_vld[0] <= 1'b0;
    end else if (en) begin
      p1_vld[0] <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // rotate the left half-plane by half a turn so the vectoring starts with a >= 0
      if (in_z < 0) begin
        p1_a[0]   <= -sz;
        p1_b[0]   <= -sx;
        p1_ang[0] <= TURN_HALF;
      end else begin
        p1_a[0]   <= sz;
        p1_b[0]   <= sx;
        p1_ang[0] <= '0;
      end
      p1_side[0].vy     <= scale_in(in_y);
      p1_side[0].y_pos  <= (in_y > 0);
      p1_side[0].y_neg  <= (in_y < 0);
      p1_side[0].u_spec <= (in_z == 0) || (in_x == 0);
      if (in_z == 0) begin
        p1_side[0].u_fix <= (in_x > 0) ? U_QUARTER : U_THREE_QUARTER;
      end else begin
        p1_side[0].u_fix <= (in_z > 0) ? U_ZERO : U_HALF;
      end
    end
  end

  for (genvar i = 0; i < NS; i++) begin : g_pass1
    always_ff @(posedge clk) begin
      if (rst) begin
        p1_vld[i+1] <= 1'b0;
      end else if (en) begin
        p1_vld[i+1] <= p1_vld[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (p1_b[i] < 0) begin
          p1_a[i+1]   <= p1_a[i] - (p1_b[i] >>> i);
          p1_b[i+1]   <= p1_b[i] + (p1_a[i] >>> i);
          p1_ang[i+1] <= p1_ang[i] - ATAN_TURNS[i];
        end else begin
          p1_a[i+1]   <= p1_a[i] + (p1_b[i] >>> i);
          p1_b[i+1]   <= p1_b[i] - (p1_a[i] >>> i);
          p1_ang[i+1] <= p1_ang[i] + ATAN_TURNS[i];
        end
        p1_side[i+1] <= p1_side[i];
      end
    end
  end

  // gain compensation multiply and u rounding
  logic                 mul_vld;
  logic signed [PW-1:0] mul_prod;
  p1_side_t             mul_side;
  logic [FIELD_W-1:0]   mul_u;
  logic [ANG1_W-1:0]    u_round;
  assign u_round = p1_ang[NS] + ANG1_W'(32768);

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_vld <= 1'b0;
    end else if (en) begin
      mul_vld <= p1_vld[NS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mul_prod <= PW'(p1_a[NS]) * PW'($signed(INV_GAIN_Q16));
      mul_side <= p1_side[NS];
      mul_u    <= p1_side[NS].u_spec ? p1_side[NS].u_fix : u_round[31:16];
    end
  end

  // radius rounding and pass two setup
  logic signed [PW-1:0] r_full;
  assign r_full = (mul_prod + PW'(32768)) >>> 16;

  logic                 p2_vld  [NS+1];
  logic signed [AW-1:0] p2_a    [NS+1];
  logic signed [AW-1:0] p2_b    [NS+1];
  logic [ANG2_W-1:0]    p2_ang  [NS+1];
  p2_side_t             p2_side [NS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      p2_vld[0] <= 1'b0;
    end else if (en) begin
      p2_vld[0] <= mul_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (mul_side.vy < 0) begin
        p2_a[0]   <= r_full[AW-1:0];
        p2_b[0]   <= -mul_side.vy;
        p2_ang[0] <= TURN_QUARTER;
      end else begin
        p2_a[0]   <= mul_side.vy;
        p2_b[0]   <= r_full[AW-1:0];
        p2_ang[0] <= '0;
      end
      p2_side[0].u      <= mul_u;
      // no horizontal radius: pole or origin
      p2_side[0].v_spec <= (r_full <= 0);
      if (mul_side.y_pos) begin
        p2_side[0].v_fix <= V_ZERO;
      end else if (mul_side.y_neg) begin
        p2_side[0].v_fix <= V_MAX;
      end else begin
        p2_side[0].v_fix <= V_HALF;
      end
    end
  end

  for (genvar i = 0; i < NS; i++) begin : g_pass2
    always_ff @(posedge clk) begin
      if (rst) begin
        p2_vld[i+1] <= 1'b0;
      end else if (en) begin
        p2_vld[i+1] <= p2_vld[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (p2_b[i] < 0) begin
          p2_a[i+1]   <= p2_a[i] - (p2_b[i] >>> i);
          p2_b[i+1]   <= p2_b[i] + (p2_a[i] >>> i);
          p2_ang[i+1] <= p2_ang[i] - ANG2_W'(ATAN_TURNS[i]);
        end else begin
          p2_a[i+1]   <= p2_a[i] + (p2_b[i] >>> i);
          p2_b[i+1]   <= p2_b[i] - (p2_a[i] >>> i);
          p2_ang[i+1] <= p2_ang[i] + ANG2_W'(ATAN_TURNS[i]);
        end
        p2_side[i+1] <= p2_side[i];
      end
    end
  end

  // output register: clamp at zero, round to 1/65536 of half a turn, saturate
  logic signed [ANG2_W-1:0] ang_fin;
  logic [ANG2_W:0]          v_sum;
  logic [ANG2_W-15:0]       v_wide;
  logic [FIELD_W-1:0]       v_calc;

  assign ang_fin = p2_ang[NS];
  assign v_sum   = (ang_fin < 0) ? (ANG2_W+1)'(16384)
                                 : {1'b0, p2_ang[NS]} + (ANG2_W+1)'(16384);
  assign v_wide  = v_sum[ANG2_W:15];
  assign v_calc  = (v_wide > (ANG2_W-14)'(V_MAX)) ? V_MAX : v_wide[FIELD_W-1:0];

  logic               out_vld;
  logic [FIELD_W-1:0] out_u;
  logic [FIELD_W-1:0] out_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= p2_vld[NS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_u <= p2_side[NS].u;
      out_v <= p2_side[NS].v_spec ? p2_side[NS].v_fix : v_calc;
    end
  end

  assign m_tvalid = out_vld;
  assign m_tdata  = {out_v, out_u};

endmodule
